[design/polyline_stroke_tessellator_defines.svh]
// assertion macros for the polyline stroke tessellator checker
// needs clock and reset in the scope where a macro is used
`ifndef POLYLINE_STROKE_TESSELLATOR_DEFINES_SVH
`define POLYLINE_STROKE_TESSELLATOR_DEFINES_SVH

// consequent checked in the same cycle
`define PST_ASSERT_SAME(label, ante, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (conseq)) \
      else $error(msg);

// consequent checked in the next cycle
`define PST_ASSERT_NEXT(label, ante, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (conseq)) \
      else $error(msg);

`endif

[design/pst_pkg.sv]
// shared constants, types and controller/datapath command structs
// for the polyline stroke tessellator; no dependencies
`default_nettype none

package pst_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 4;

   // unit normal is unsigned q1.15
   localparam int UNIT_BITS    = 15;
   localparam int SQ_BITS      = 2 * UNIT_BITS;
   localparam int S_BITS       = SQ_BITS + 1;
   localparam int ROOT_SHIFT   = 2 * (UNIT_BITS + 1);
   localparam int ROOT_BITS    = S_BITS + ROOT_SHIFT + 1;
   localparam int V_BITS       = UNIT_BITS + 2;
   localparam int BIT_IDX_BITS = $clog2(V_BITS);
   localparam int M_BITS       = UNIT_BITS + 1;

   localparam int THICK_BITS   = 8;
   localparam int THICK_Q_BITS = THICK_BITS + FRAC_BITS;
   localparam int PROD_BITS    = M_BITS + THICK_Q_BITS;
   localparam int OFF_MAG_BITS = PROD_BITS + 1 - (UNIT_BITS + 1);
   localparam int OFF_BITS     = OFF_MAG_BITS + 1;
   localparam int SUM_BITS     = ((COORD_BITS > OFF_BITS) ? COORD_BITS : OFF_BITS) + 1;

   localparam int VTX_COUNT    = 6;
   localparam int VTX_IDX_BITS = $clog2(VTX_COUNT);
   // per vertex: base is first point, offset is added
   localparam logic [VTX_COUNT-1:0] VTX_FROM_P = 6'b001101;
   localparam logic [VTX_COUNT-1:0] VTX_ADD    = 6'b011001;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                     load_item;
      logic                     load_first;
      logic                     start_close;
      logic                     calc_delta;
      logic                     norm_shift;
      logic                     clear_offset;
      logic                     sq_a;
      logic                     sq_b;
      logic                     sq_c;
      logic                     root_init;
      logic                     root_step;
      logic [BIT_IDX_BITS-1:0]  root_bit;
      logic                     comp_sel;
      logic                     scale;
      logic [VTX_IDX_BITS-1:0]  vtx_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic big;
      logic zero_len;
   } dp_stat_type;

endpackage

`default_nettype wire

[design/pst_req_if.sv]
// input channel carrying polyline points
// depends on pst_pkg
`default_nettype none

interface pst_req_if import pst_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   logic      end_of_list;

   modport source (output valid, point_x, point_y, end_of_list, input ready);
   modport sink (input valid, point_x, point_y, end_of_list, output ready);
endinterface

`default_nettype wire

[design/pst_rsp_if.sv]
// result channel carrying triangle vertices
// depends on pst_pkg
`default_nettype none

interface pst_rsp_if import pst_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type vertex_x;
   coord_type vertex_y;
   logic      last_vertex;

   modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

`default_nettype wire

[design/pst_csr.sv]
// apb register file: line thickness and closed loop mode
// depends on pst_pkg
`default_nettype none

module pst_csr import pst_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output logic      [THICK_BITS-1:0]    thickness,
   output logic                          closed_loop
);

   typedef enum logic {
      REG_THICKNESS = 1'b0,
      REG_CLOSED    = 1'b1
   } reg_idx_type;

   logic [THICK_BITS-1:0] thick_ff, thick_in;
   logic                  closed_ff, closed_in;
   reg_idx_type           idx;
   logic                  wr_en;

   assign idx   = reg_idx_type'(paddr[2]);
   assign wr_en = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      thick_in  = thick_ff;
      closed_in = closed_ff;
      prdata    = '0;
      unique case (idx)
         REG_THICKNESS: begin
            prdata = CSR_DATA_BITS'(thick_ff);
            if (wr_en) thick_in = pwdata[THICK_BITS-1:0];
         end
         REG_CLOSED: begin
            prdata = CSR_DATA_BITS'(closed_ff);
            if (wr_en) closed_in = pwdata[0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thick_ff  <= THICK_BITS'(1);
         closed_ff <= 1'b0;
      end else begin
         thick_ff  <= thick_in;
         closed_ff <= closed_in;
      end
   end

   assign thickness   = thick_ff;
   assign closed_loop = closed_ff;

endmodule

`default_nettype wire

[design/pst_ctrl.sv]
// sequencer: point bookkeeping, normalization steps and vertex beats
// depends on pst_pkg; drives pst_dpath through dp_cmd_type
`default_nettype none

module pst_ctrl import pst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_end,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_last,
   input  wire logic        closed_loop,
   output dp_cmd_type       cmd,
   input  wire dp_stat_type stat
);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_DELTA = 10'b0000000010,
      ST_NORM  = 10'b0000000100,
      ST_SQA   = 10'b0000001000,
      ST_SQB   = 10'b0000010000,
      ST_SQC   = 10'b0000100000,
      ST_RINIT = 10'b0001000000,
      ST_ROOT  = 10'b0010000000,
      ST_SCALE = 10'b0100000000,
      ST_EMIT  = 10'b1000000000
   } state_type;

   localparam logic [VTX_IDX_BITS-1:0] VTX_LAST = VTX_IDX_BITS'(VTX_COUNT - 1);

   state_type               state_ff, state_in;
   logic [1:0]              seen_ff, seen_in;
   logic                    close_ff, close_in;
   logic [BIT_IDX_BITS-1:0] bit_ff, bit_in;
   logic                    comp_ff, comp_in;
   logic [VTX_IDX_BITS-1:0] vtx_ff, vtx_in;

   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      close_in = close_ff;
      bit_in   = bit_ff;
      comp_in  = comp_ff;
      vtx_in   = vtx_ff;
      cmd          = '0;
      cmd.root_bit = bit_ff;
      cmd.comp_sel = comp_ff;
      cmd.vtx_sel  = vtx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item  = 1'b1;
               cmd.load_first = (seen_ff == 2'd0);
               close_in = req_end && closed_loop && (seen_ff != 2'd0);
               if (req_end) seen_in = 2'd0;
               else if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
               if (seen_ff != 2'd0) state_in = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.calc_delta = 1'b1;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (stat.big) begin
               cmd.norm_shift = 1'b1;
            end else if (stat.zero_len) begin
               // degenerate segment, no offset
               cmd.clear_offset = 1'b1;
               vtx_in   = '0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SQA;
            end
         end
         ST_SQA: begin
            cmd.sq_a = 1'b1;
            state_in = ST_SQB;
         end
         ST_SQB: begin
            cmd.sq_b = 1'b1;
            state_in = ST_SQC;
         end
         ST_SQC: begin
            cmd.sq_c = 1'b1;
            comp_in  = 1'b0;
            state_in = ST_RINIT;
         end
         ST_RINIT: begin
            cmd.root_init = 1'b1;
            bit_in   = BIT_IDX_BITS'(V_BITS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (bit_ff == '0) state_in = ST_SCALE;
            else bit_in = bit_ff - 1'b1;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            if (!comp_ff) begin
               comp_in  = 1'b1;
               state_in = ST_RINIT;
            end else begin
               vtx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (vtx_ff == VTX_LAST) begin
                  if (close_ff) begin
                     // closing segment: last point back to first
                     cmd.start_close = 1'b1;
                     close_in = 1'b0;
                     state_in = ST_DELTA;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  vtx_in = vtx_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_last = (vtx_ff == VTX_LAST) && !close_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= 2'd0;
         close_ff <= 1'b0;
         bit_ff   <= '0;
         comp_ff  <= 1'b0;
         vtx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         close_ff <= close_in;
         bit_ff   <= bit_in;
         comp_ff  <= comp_in;
         vtx_ff   <= vtx_in;
      end
   end

endmodule

`default_nettype wire

[design/pst_dpath.sv]
// datapath: point registers, delta, bit-serial unit normal search,
// offset scaling and saturated vertex output; depends on pst_pkg
`default_nettype none

module pst_dpath import pst_pkg::*; (
   input  wire logic                  clock,
   input  wire dp_cmd_type            cmd,
   output dp_stat_type                stat,
   input  wire coord_type             in_x,
   input  wire coord_type             in_y,
   input  wire logic [THICK_BITS-1:0] thickness,
   output coord_type                  vertex_x,
   output coord_type                  vertex_y
);

   typedef logic signed [OFF_BITS-1:0] off_type;
   typedef logic signed [SUM_BITS-1:0] sum_type;

   coord_type prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   coord_type first_x_ff, first_x_in, first_y_ff, first_y_in;
   coord_type p_x_ff, p_x_in, p_y_ff, p_y_in;
   coord_type q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic [COORD_BITS-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic                  ox_neg_ff, ox_neg_in, oy_neg_ff, oy_neg_in;
   logic [SQ_BITS-1:0]    axsq_ff, axsq_in, aysq_ff, aysq_in;
   logic [S_BITS-1:0]     s_ff, s_in;
   logic [ROOT_BITS-1:0]  rem_ff, rem_in, t1_ff, t1_in, t2_ff, t2_in;
   logic [V_BITS-1:0]     v_ff, v_in;
   off_type               ox_ff, ox_in, oy_ff, oy_in;

   logic signed [COORD_BITS:0] dx, dy;
   logic [ROOT_BITS:0]         trial;
   logic                       fits;
   logic [V_BITS:0]            v_inc;
   logic [M_BITS-1:0]          m;
   logic [PROD_BITS-1:0]       prod;
   logic [PROD_BITS:0]         rounded;
   logic [OFF_MAG_BITS-1:0]    mag;
   off_type                    off_signed;
   logic                       off_neg;

   assign dx = (COORD_BITS+1)'(q_x_ff) - (COORD_BITS+1)'(p_x_ff);
   assign dy = (COORD_BITS+1)'(q_y_ff) - (COORD_BITS+1)'(p_y_ff);

   // one restoring step of the largest v with v*v*s <= a*a*2^32
   assign trial = {1'b0, t1_ff} + {1'b0, t2_ff};
   assign fits  = {1'b0, rem_ff} >= trial;

   // unit magnitude is ceil(v/2), then scaled by thickness and rounded
   assign v_inc      = {1'b0, v_ff} + (V_BITS+1)'(1);
   assign m          = v_inc[M_BITS:1];
   assign prod       = PROD_BITS'(m) * PROD_BITS'({thickness, {FRAC_BITS{1'b0}}});
   assign rounded    = {1'b0, prod} + ((PROD_BITS+1)'(1) << UNIT_BITS);
   assign mag        = rounded[PROD_BITS:UNIT_BITS+1];
   assign off_neg    = cmd.comp_sel ? oy_neg_ff : ox_neg_ff;
   assign off_signed = off_neg ? -off_type'({1'b0, mag}) : off_type'({1'b0, mag});

   assign stat.big      = (|ax_ff[COORD_BITS-1:UNIT_BITS]) || (|ay_ff[COORD_BITS-1:UNIT_BITS]);
   assign stat.zero_len = (ax_ff == '0) && (ay_ff == '0);

   always_comb begin
      prev_x_in = prev_x_ff;  prev_y_in = prev_y_ff;
      first_x_in = first_x_ff; first_y_in = first_y_ff;
      p_x_in = p_x_ff; p_y_in = p_y_ff;
      q_x_in = q_x_ff; q_y_in = q_y_ff;
      ax_in = ax_ff; ay_in = ay_ff;
      ox_neg_in = ox_neg_ff; oy_neg_in = oy_neg_ff;
      axsq_in = axsq_ff; aysq_in = aysq_ff; s_in = s_ff;
      rem_in = rem_ff; t1_in = t1_ff; t2_in = t2_ff; v_in = v_ff;
      ox_in = ox_ff; oy_in = oy_ff;
      if (cmd.load_item) begin
         p_x_in = prev_x_ff;
         p_y_in = prev_y_ff;
         q_x_in = in_x;
         q_y_in = in_y;
         prev_x_in = in_x;
         prev_y_in = in_y;
         if (cmd.load_first) begin
            first_x_in = in_x;
            first_y_in = in_y;
         end
      end
      if (cmd.start_close) begin
         p_x_in = q_x_ff;
         p_y_in = q_y_ff;
         q_x_in = first_x_ff;
         q_y_in = first_y_ff;
      end
      if (cmd.calc_delta) begin
         ax_in = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
         ay_in = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
         ox_neg_in = !dy[COORD_BITS] && (dy != '0);
         oy_neg_in = dx[COORD_BITS];
      end
      if (cmd.norm_shift) begin
         ax_in = ax_ff >> 1;
         ay_in = ay_ff >> 1;
      end
      if (cmd.sq_a) axsq_in = SQ_BITS'(ax_ff[UNIT_BITS-1:0]) * SQ_BITS'(ax_ff[UNIT_BITS-1:0]);
      if (cmd.sq_b) aysq_in = SQ_BITS'(ay_ff[UNIT_BITS-1:0]) * SQ_BITS'(ay_ff[UNIT_BITS-1:0]);
      if (cmd.sq_c) s_in = {1'b0, axsq_ff} + {1'b0, aysq_ff};
      if (cmd.clear_offset) begin
         ox_in = '0;
         oy_in = '0;
      end
      if (cmd.root_init) begin
         // x component uses |dy|, y component uses |dx|
         rem_in = ROOT_BITS'(cmd.comp_sel ? axsq_ff : aysq_ff) << ROOT_SHIFT;
         t1_in  = '0;
         t2_in  = ROOT_BITS'(s_ff) << ROOT_SHIFT;
         v_in   = '0;
      end
      if (cmd.root_step) begin
         t2_in = t2_ff >> 2;
         if (fits) begin
            rem_in = rem_ff - trial[ROOT_BITS-1:0];
            t1_in  = (t1_ff >> 1) + t2_ff;
            v_in[cmd.root_bit] = 1'b1;
         end else begin
            t1_in = t1_ff >> 1;
         end
      end
      if (cmd.scale) begin
         if (cmd.comp_sel) oy_in = off_signed;
         else ox_in = off_signed;
      end
   end

   always_ff @(posedge clock) begin
      prev_x_ff <= prev_x_in;  prev_y_ff <= prev_y_in;
      first_x_ff <= first_x_in; first_y_ff <= first_y_in;
      p_x_ff <= p_x_in; p_y_ff <= p_y_in;
      q_x_ff <= q_x_in; q_y_ff <= q_y_in;
      ax_ff <= ax_in; ay_ff <= ay_in;
      ox_neg_ff <= ox_neg_in; oy_neg_ff <= oy_neg_in;
      axsq_ff <= axsq_in; aysq_ff <= aysq_in; s_ff <= s_in;
      rem_ff <= rem_in; t1_ff <= t1_in; t2_ff <= t2_in; v_ff <= v_in;
      ox_ff <= ox_in; oy_ff <= oy_in;
   end

   function automatic coord_type saturate(input sum_type v);
      logic ovf;
      ovf = (v[SUM_BITS-1:COORD_BITS-1] != '0) && (v[SUM_BITS-1:COORD_BITS-1] != '1);
      if (!ovf) return v[COORD_BITS-1:0];
      else if (v[SUM_BITS-1]) return {1'b1, {(COORD_BITS-1){1'b0}}};
      else return {1'b0, {(COORD_BITS-1){1'b1}}};
   endfunction

   logic    use_p, add_off;
   sum_type sum_x, sum_y;

   assign use_p   = VTX_FROM_P[cmd.vtx_sel];
   assign add_off = VTX_ADD[cmd.vtx_sel];
   assign sum_x = sum_type'(use_p ? p_x_ff : q_x_ff)
                + (add_off ? sum_type'(ox_ff) : -sum_type'(ox_ff));
   assign sum_y = sum_type'(use_p ? p_y_ff : q_y_ff)
                + (add_off ? sum_type'(oy_ff) : -sum_type'(oy_ff));

   assign vertex_x = saturate(sum_x);
   assign vertex_y = saturate(sum_y);

endmodule

`default_nettype wire

[design/polyline_stroke_tessellator.sv]
// Polyline stroke tessellator, top level.
// Points enter on req (valid/ready); each segment leaves on rsp as six
// vertices P+nh, Q-nh, P-nh, P+nh, Q+nh, Q-nh, last_vertex on the final
// vertex an input causes. Line thickness and closed mode sit behind the
// csr apb port; the user must write them only while the block is idle,
// as the block itself does not enforce this. One point at a time:
// req_ready is high only when the block is idle. A first point is stored
// and emits nothing. The first vertex of a segment follows the point beat
// after delta, range check, three squaring steps, then per normal
// component one init step, 17 steps of the shared bit-serial square root
// search and one scale step. The range check repeats a shift while the
// delta is too large; a zero-length segment goes from the range check
// straight to its vertices. Then one vertex per cycle while rsp_ready is
// high; a closing point runs the segment sequence twice (12 vertices).
// A stalled receiver holds the current vertex steady; no new point is
// taken until the last vertex is delivered. Synchronous reset clears
// the point count, thickness to one pixel and closed mode off.
// Depends on pst_pkg, pst_req_if, pst_rsp_if, pst_csr, pst_ctrl, pst_dpath.
`default_nettype none

module polyline_stroke_tessellator import pst_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   pst_req_if.sink                       req,
   pst_rsp_if.source                     rsp,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   logic [THICK_BITS-1:0] thickness;
   logic                  closed_loop;
   dp_cmd_type            cmd;
   dp_stat_type           stat;

   pst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (csr_psel),
      .penable     (csr_penable),
      .pwrite      (csr_pwrite),
      .paddr       (csr_paddr),
      .pwdata      (csr_pwdata),
      .prdata      (csr_prdata),
      .pready      (csr_pready),
      .thickness   (thickness),
      .closed_loop (closed_loop)
   );

   pst_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_end     (req.end_of_list),
      .req_ready   (req.ready),
      .rsp_valid   (rsp.valid),
      .rsp_ready   (rsp.ready),
      .rsp_last    (rsp.last_vertex),
      .closed_loop (closed_loop),
      .cmd         (cmd),
      .stat        (stat)
   );

   pst_dpath u_dpath (
      .clock     (clock),
      .cmd       (cmd),
      .stat      (stat),
      .in_x      (req.point_x),
      .in_y      (req.point_y),
      .thickness (thickness),
      .vertex_x  (rsp.vertex_x),
      .vertex_y  (rsp.vertex_y)
   );

endmodule

`default_nettype wire

[design/pst_checker.sv]
// port-level checks for the polyline stroke tessellator, bound to the top
// depends on pst_pkg and polyline_stroke_tessellator_defines.svh
`default_nettype none

`include "polyline_stroke_tessellator_defines.svh"

module pst_checker import pst_pkg::*; (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      req_valid,
   input wire logic      req_ready,
   input wire logic      rsp_valid,
   input wire logic      rsp_ready,
   input wire coord_type rsp_x,
   input wire coord_type rsp_y,
   input wire logic      rsp_last
);

   // stalled vertex beat stays put
   `PST_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x) && $stable(rsp_y) && $stable(rsp_last), "rsp beat changed while stalled")

   // one point in flight: no new point while vertices are pending
   `PST_ASSERT_SAME(a_no_overlap, rsp_valid, !req_ready, "req ready while vertices pending")

   // a vertex never shows the cycle after a point is taken
   `PST_ASSERT_NEXT(a_no_instant, req_valid && req_ready, !rsp_valid, "vertex right after point beat")

   // after the last vertex the block is idle again
   `PST_ASSERT_NEXT(a_idle_after_last, rsp_valid && rsp_ready && rsp_last, req_ready && !rsp_valid, "not idle after last vertex")

endmodule

bind polyline_stroke_tessellator pst_checker u_pst_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_x     (rsp.vertex_x),
   .rsp_y     (rsp.vertex_y),
   .rsp_last  (rsp.last_vertex)
);

`default_nettype wire
